FILE: rtl/ksrt_pkg.sv
// shared types and constants for the keyed slew ramp table
package ksrt_pkg;

	localparam int unsigned KEY_W   = 32;
	localparam int unsigned LEVEL_W = 17;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned GAIN_W  = 16;
	localparam int unsigned SNAP_W  = 24;
	localparam int unsigned PROD_W  = TIME_W + GAIN_W;
	localparam int unsigned IN_W    = 72;
	localparam int unsigned OUT_W   = 24;
	localparam int unsigned CIDX_W  = 8;

	localparam logic [LEVEL_W-1:0] FULL_SCALE = LEVEL_W'(65536);
	localparam logic [GAIN_W-1:0]  GAIN_RESET = GAIN_W'(47722);
	localparam logic [SNAP_W-1:0]  SNAP_RESET = SNAP_W'(1000000);

	// configuration register indexes
	localparam logic [CIDX_W-1:0] REG_RAMP_GAIN  = CIDX_W'(0);
	localparam logic [CIDX_W-1:0] REG_SNAP_LIMIT = CIDX_W'(1);

	// one slot of the table
	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [LEVEL_W-1:0] level;
		logic [TIME_W-1:0]  seen;
	} slot_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CALC,
		ST_WRITE,
		ST_DONE
	} state_t;

endpackage

FILE: rtl/ksrt_cell.sv
// one slot cell of the rotating table ring
module ksrt_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           shift_en,
	input  ksrt_pkg::slot_t d,
	output ksrt_pkg::slot_t q
);
	import ksrt_pkg::*;

	slot_t slot_q;

	// take the neighbor's slot whenever the ring rotates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (shift_en) begin
			slot_q <= d;
		end
	end

	assign q = slot_q;

endmodule

FILE: rtl/ksrt_step.sv
// ramp update: elapsed time, gain product, then clamp at the goal
module ksrt_step (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          hit,
	input  logic                          goal_on,
	input  logic [ksrt_pkg::LEVEL_W-1:0]  level,
	input  logic [ksrt_pkg::TIME_W-1:0]   seen,
	input  logic [ksrt_pkg::TIME_W-1:0]   now_us,
	input  logic [ksrt_pkg::GAIN_W-1:0]   gain,
	input  logic [ksrt_pkg::SNAP_W-1:0]   snap,
	output logic                          done,
	output logic [ksrt_pkg::LEVEL_W-1:0]  new_level,
	output logic                          moving
);
	import ksrt_pkg::*;

	logic [TIME_W-1:0]  elapsed;
	logic               in_win;
	logic               v_s1;
	logic               win_s1;
	logic [PROD_W-1:0]  prod_s1;
	logic [LEVEL_W-1:0] lvl_s1;
	logic [LEVEL_W-1:0] goal_s1;
	logic               v_s2;
	logic [LEVEL_W-1:0] level_s2;
	logic               moving_s2;
	logic [TIME_W-1:0]  step;
	logic [TIME_W:0]    up;
	logic [LEVEL_W-1:0] diff;
	logic [LEVEL_W-1:0] nxt;

	// window test; a newly taken slot counts from a zero stamp and starts at goal
	assign elapsed = now_us - (hit ? seen : '0);
	assign in_win  = (elapsed != '0) && (elapsed < {{(TIME_W-SNAP_W){1'b0}}, snap});

	// stage 1: product and window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1 <= PROD_W'(elapsed) * PROD_W'(gain);
			win_s1  <= in_win;
			goal_s1 <= goal_on ? FULL_SCALE : '0;
			lvl_s1  <= hit ? level : (goal_on ? FULL_SCALE : '0);
		end
	end

	// clamp toward the goal
	assign step = prod_s1[PROD_W-1:GAIN_W];
	assign up   = {1'b0, {(TIME_W-LEVEL_W){1'b0}}, lvl_s1} + {1'b0, step};
	assign diff = lvl_s1 - goal_s1;

	always_comb begin
		nxt = goal_s1;
		if (win_s1) begin
			if (lvl_s1 < goal_s1) begin
				if (up < {{(TIME_W+1-LEVEL_W){1'b0}}, goal_s1}) nxt = up[LEVEL_W-1:0];
			end else if (lvl_s1 > goal_s1) begin
				if (step < {{(TIME_W-LEVEL_W){1'b0}}, diff}) nxt = lvl_s1 - step[LEVEL_W-1:0];
			end else begin
				nxt = lvl_s1;
			end
		end
	end

	// stage 2: result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			level_s2  <= nxt;
			moving_s2 <= (nxt != goal_s1);
		end
	end

	assign done      = v_s2;
	assign new_level = level_s2;
	assign moving    = moving_s2;

endmodule

FILE: rtl/keyed_slew_ramp_table.sv
// keyed slew ramp table: one request in, one ramp level out
// the request is captured, a scan turn and the ramp math follow, then a write turn, and the
// result goes to the output register; a new request is taken only in idle, and a result still
// waiting at the end of the write turn holds the block until it is taken
// the slot ring rotates one cell per cycle in the scan and write turns: a full scan turn finds
// the key or the victim, the ramp math holds the ring, a second full turn writes the slot back
// reset clears every slot to zero and loads the register defaults
module keyed_slew_ramp_table #(
	parameter int unsigned SLOT_COUNT = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ksrt_pkg::IN_W-1:0]     s_tdata,   // key[31:0], target_on[32], now_us[64:33]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ksrt_pkg::OUT_W-1:0]    m_tdata,   // level[16:0], moving[17]
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ksrt_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [ksrt_pkg::SNAP_W-1:0]   cfg_data
);
	import ksrt_pkg::*;

	localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

	state_t state_q, state_d;

	logic [KEY_W-1:0]   key_q;
	logic               goal_on_q;
	logic [TIME_W-1:0]  now_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [SNAP_W-1:0]  snap_q;
	logic [IW-1:0]      cnt_q;
	logic               found_q;
	logic [IW-1:0]      hit_idx_q;
	logic [LEVEL_W-1:0] cap_level_q;
	logic [TIME_W-1:0]  cap_seen_q;
	logic [TIME_W-1:0]  min_seen_q;
	logic [IW-1:0]      vict_q;
	logic               go_q;
	logic [LEVEL_W-1:0] new_level_q;
	logic               moving_q;
	logic               out_valid_q;
	logic [LEVEL_W-1:0] out_level_q;
	logic               out_moving_q;

	slot_t ring [SLOT_COUNT];
	slot_t head_in;
	slot_t head;
	logic  shift_en;
	logic  write_head;
	logic  cnt_last;
	logic  hit_now;
	logic  less_now;
	logic  in_xfer;
	logic  step_done;
	logic [LEVEL_W-1:0] step_level;
	logic               step_moving;
	logic [IW-1:0]      tgt_idx;

	// ring of slot cells; cell 0 is the head, the tail takes the head back
	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		if (i == SLOT_COUNT - 1) begin : g_tail
			ksrt_cell u_cell (.clk(clk), .arst_n(arst_n), .shift_en(shift_en),
				.d(head_in), .q(ring[i]));
		end else begin : g_mid
			ksrt_cell u_cell (.clk(clk), .arst_n(arst_n), .shift_en(shift_en),
				.d(ring[i+1]), .q(ring[i]));
		end
	end

	assign head     = ring[0];
	assign cnt_last = (cnt_q == LAST_IDX);
	assign hit_now  = !found_q && (head.key == key_q);
	assign less_now = (cnt_q == '0) || (head.seen < min_seen_q);
	assign tgt_idx  = found_q ? hit_idx_q : vict_q;
	assign in_xfer  = s_tvalid && s_tready;

	// updated slot replaces the head when it passes the target place
	always_comb begin
		head_in = head;
		if (write_head) begin
			head_in.key   = key_q;
			head_in.level = new_level_q;
			head_in.seen  = now_q;
		end
	end

	ksrt_step u_step (
		.clk(clk), .arst_n(arst_n), .start(go_q), .hit(found_q),
		.goal_on(goal_on_q), .level(cap_level_q), .seen(cap_seen_q),
		.now_us(now_q), .gain(gain_q), .snap(snap_q),
		.done(step_done), .new_level(step_level), .moving(step_moving)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_xfer) state_d = ST_SCAN;
			ST_SCAN:  if (cnt_last) state_d = ST_CALC;
			ST_CALC:  if (step_done) state_d = ST_WRITE;
			ST_WRITE: if (cnt_last) state_d = ST_DONE;
			ST_DONE:  if (!out_valid_q || m_tready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_tready   = 1'b0;
		shift_en   = 1'b0;
		write_head = 1'b0;
		case (state_q)
			ST_IDLE:  s_tready = 1'b1;
			ST_SCAN:  shift_en = 1'b1;
			ST_WRITE: begin
				shift_en   = 1'b1;
				write_head = (cnt_q == tgt_idx);
			end
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			found_q <= 1'b0;
			go_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			go_q    <= (state_q == ST_SCAN) && cnt_last;
			if (in_xfer) begin
				found_q <= 1'b0;
			end else if (state_q == ST_SCAN && hit_now) begin
				found_q <= 1'b1;
			end
			if (shift_en) begin
				cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
			end
		end
	end

	// request capture and scan bookkeeping
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			key_q     <= s_tdata[31:0];
			goal_on_q <= s_tdata[32];
			now_q     <= s_tdata[64:33];
		end
		if (state_q == ST_SCAN) begin
			if (hit_now) begin
				hit_idx_q   <= cnt_q;
				cap_level_q <= head.level;
				cap_seen_q  <= head.seen;
			end
			if (less_now) begin
				min_seen_q <= head.seen;
				vict_q     <= cnt_q;
			end
		end
		if (state_q == ST_CALC && step_done) begin
			new_level_q <= step_level;
			moving_q    <= step_moving;
		end
	end

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
			snap_q <= SNAP_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_RAMP_GAIN:  gain_q <= cfg_data[GAIN_W-1:0];
				REG_SNAP_LIMIT: snap_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!out_valid_q || m_tready)) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || m_tready)) begin
			out_level_q  <= new_level_q;
			out_moving_q <= moving_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_W-LEVEL_W-1){1'b0}}, out_moving_q, out_level_q};

endmodule
